@@ rtl/tbpr_pkg.sv @@
package tbpr_pkg;

    // Video memory: four byte banks, interleaved on address bits [1:0]
    localparam int VRAM_BYTES     = 16384;
    localparam int VRAM_AW        = 14;
    localparam int BANKS          = 4;
    localparam int BANK_DEPTH     = VRAM_BYTES / BANKS;
    localparam int BANK_AW        = 12;
    localparam int PAL_ENTRIES    = 32;
    localparam int PAL_AW         = 5;
    localparam int COLOUR_W       = 6;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 8;
    localparam int ROWS           = 28;

    // Item kinds
    localparam logic [1:0] KIND_VRAM_WRITE = 2'd0;
    localparam logic [1:0] KIND_PAL_WRITE  = 2'd1;
    localparam logic [1:0] KIND_RENDER     = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NAME_TABLE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAN_X       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAN_Y       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCK_TOP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_LEFT   = 3'd4;

    localparam logic [2:0] NAME_TABLE_RESET = 3'd7;

    typedef struct packed {
        logic               we;
        logic [BANK_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [BANK_AW-1:0] raddr;
    } bank_req_t;

    typedef struct packed {
        logic                we;
        logic [PAL_AW-1:0]   waddr;
        logic [COLOUR_W-1:0] wdata;
    } pal_wr_t;

    function automatic logic [COLOUR_W-1:0] default_colour(input logic [3:0] idx);
        logic [COLOUR_W-1:0] c;
        unique case (idx)
            4'd0:    c = 6'h00;
            4'd1:    c = 6'h00;
            4'd2:    c = 6'h08;
            4'd3:    c = 6'h0C;
            4'd4:    c = 6'h10;
            4'd5:    c = 6'h30;
            4'd6:    c = 6'h01;
            4'd7:    c = 6'h3C;
            4'd8:    c = 6'h02;
            4'd9:    c = 6'h03;
            4'd10:   c = 6'h05;
            4'd11:   c = 6'h0F;
            4'd12:   c = 6'h04;
            4'd13:   c = 6'h33;
            4'd14:   c = 6'h15;
            default: c = 6'h3F;
        endcase
        return c;
    endfunction

    // Tile row modulo 28 for a 6-bit row number (below three times 28)
    function automatic logic [4:0] row_wrap(input logic [5:0] tile);
        logic [5:0] r;
        if (tile >= 6'(2 * ROWS))
            r = tile - 6'(2 * ROWS);
        else if (tile >= 6'(ROWS))
            r = tile - 6'(ROWS);
        else
            r = tile;
        return r[4:0];
    endfunction

endpackage

@@ rtl/tbpr_vram_bank.sv @@
module tbpr_vram_bank
(
    input  logic                 clk,
    input  tbpr_pkg::bank_req_t  req,
    output logic [7:0]           rdata
);

    logic [7:0] mem_reg [tbpr_pkg::BANK_DEPTH];
    logic [7:0] rdata_reg;

    // Read returns the old byte on a same-address write
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem_reg[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tbpr_palette.sv @@
module tbpr_palette
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tbpr_pkg::pal_wr_t                  wr,
    input  logic [tbpr_pkg::PAL_AW-1:0]        raddr,
    output logic [tbpr_pkg::COLOUR_W-1:0]      rdata
);

    logic [tbpr_pkg::COLOUR_W-1:0] pal_reg [tbpr_pkg::PAL_ENTRIES];

    // Load the default table into both halves on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tbpr_pkg::PAL_ENTRIES; i++)
            begin
                pal_reg[i] <= tbpr_pkg::default_colour(4'(i));
            end
        end
        else if (wr.we)
        begin
            pal_reg[wr.waddr] <= wr.wdata;
        end
    end

    assign rdata = pal_reg[raddr];

endmodule

@@ rtl/tile_background_pixel_renderer.sv @@
// A render beat accepted issues the name-word read; the N stage then issues the pattern
//   line read, and the P stage does the palette lookup into the output colour register.
// The input stalls while a render is in the N stage, set by the two dependent reads (name word,
//   then pattern line) on the single read port of the banked video memory, and while
//   P cannot drain; memory writes and ignored kinds do not hold the input.
// Reset: registers to their defaults, palette to the default table, pipeline empty.
module tile_background_pixel_renderer
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration port
    input  logic                                   cfg_we,
    input  logic [tbpr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [tbpr_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             kind,
    input  logic [tbpr_pkg::VRAM_AW-1:0]           address,
    input  logic [7:0]                             write_data,
    input  logic [7:0]                             screen_x,
    input  logic [7:0]                             screen_y,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [tbpr_pkg::COLOUR_W-1:0]          colour
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0] name_table_reg;
    logic [7:0] pan_x_reg;
    logic [7:0] pan_y_reg;
    logic       lock_top_reg;
    logic       mask_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_table_reg <= tbpr_pkg::NAME_TABLE_RESET;
            pan_x_reg      <= '0;
            pan_y_reg      <= '0;
            lock_top_reg   <= 1'b0;
            mask_left_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbpr_pkg::CFG_NAME_TABLE: name_table_reg <= cfg_data[2:0];
                tbpr_pkg::CFG_PAN_X:      pan_x_reg      <= cfg_data;
                tbpr_pkg::CFG_PAN_Y:      pan_y_reg      <= cfg_data;
                tbpr_pkg::CFG_LOCK_TOP:   lock_top_reg   <= cfg_data[0];
                tbpr_pkg::CFG_MASK_LEFT:  mask_left_reg  <= cfg_data[0];
                default:                  ;   // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    //   accept : name-word read issued (render) or write performed
    //   N stage: name word in bank read registers, pattern read issued
    //   P stage: pattern bytes in bank read registers, palette lookup
    //   output : colour register
    // The bank read registers hold either N or P data, never both: the
    // input stalls while N is busy, and while P cannot drain.
    // ------------------------------------------------------------------
    logic                                 out_valid_reg, out_valid_next;
    logic [tbpr_pkg::COLOUR_W-1:0]        colour_reg, colour_next;
    logic                                 n_valid_reg, n_valid_next;
    logic                                 p_valid_reg, p_valid_next;
    logic                                 out_free;
    logic                                 accept;
    logic                                 accept_render;

    assign out_free      = !out_valid_reg || !out_stall;
    assign in_stall      = n_valid_reg || (p_valid_reg && !out_free);
    assign accept        = in_valid && !in_stall;
    assign accept_render = accept && (kind == tbpr_pkg::KIND_RENDER);

    // ------------------------------------------------------------------
    // Address generation for the name word
    // ------------------------------------------------------------------
    logic [7:0] hscroll;
    logic [7:0] bx;
    logic [8:0] by;
    logic [4:0] tile_row;
    logic [tbpr_pkg::BANK_AW-1:0] name_row;
    logic       mask_pixel;

    always_comb
    begin
        // lock: zero horizontal scroll on the top sixteen lines
        hscroll    = (lock_top_reg && (screen_y[7:4] == 4'd0)) ? 8'd0 : pan_x_reg;
        bx         = screen_x - hscroll;
        by         = {1'b0, screen_y} + {1'b0, pan_y_reg};
        tile_row   = tbpr_pkg::row_wrap(by[8:3]);
        // name byte address = {table, row, column, 0}; bank row drops bits [1:0]
        name_row   = {name_table_reg, tile_row, bx[7:4]};
        mask_pixel = mask_left_reg && (screen_x[7:3] == 5'd0);
    end

    // N stage payload
    logic       n_half_reg;
    logic [2:0] n_line_reg;
    logic [2:0] n_px_reg;
    logic       n_mask_reg;

    always_ff @(posedge clk)
    begin
        if (accept_render)
        begin
            n_half_reg <= bx[3];
            n_line_reg <= by[2:0];
            n_px_reg   <= bx[2:0];
            n_mask_reg <= mask_pixel;
        end
    end

    // ------------------------------------------------------------------
    // Video memory banks
    // ------------------------------------------------------------------
    logic [7:0]              bank_rdata [tbpr_pkg::BANKS];
    tbpr_pkg::bank_req_t     bank_req   [tbpr_pkg::BANKS];

    // Name word decode from the read registers
    logic [15:0] name_word;
    logic [2:0]  pat_line;
    logic [tbpr_pkg::BANK_AW-1:0] pat_row;
    logic [2:0]  pat_bitpos;

    always_comb
    begin
        // low byte first; the upper half-row holds columns with bit 0 set
        name_word  = n_half_reg ? {bank_rdata[3], bank_rdata[2]}
                                : {bank_rdata[1], bank_rdata[0]};
        pat_line   = name_word[10] ? ~n_line_reg : n_line_reg;
        pat_row    = {name_word[8:0], pat_line};
        pat_bitpos = name_word[9] ? n_px_reg : ~n_px_reg;
    end

    for (genvar b = 0; b < tbpr_pkg::BANKS; b++)
    begin : g_bank
        always_comb
        begin
            bank_req[b].we    = accept && (kind == tbpr_pkg::KIND_VRAM_WRITE)
                                && (address[1:0] == 2'(b));
            bank_req[b].waddr = address[tbpr_pkg::VRAM_AW-1:2];
            bank_req[b].wdata = write_data;
            bank_req[b].re    = accept_render || n_valid_reg;
            bank_req[b].raddr = n_valid_reg ? pat_row : name_row;
        end

        tbpr_vram_bank u_bank
        (
            .clk   (clk),
            .req   (bank_req[b]),
            .rdata (bank_rdata[b])
        );
    end

    // P stage payload
    logic [2:0] p_bitpos_reg;
    logic       p_palsel_reg;
    logic       p_mask_reg;

    always_ff @(posedge clk)
    begin
        if (n_valid_reg)
        begin
            p_bitpos_reg <= pat_bitpos;
            p_palsel_reg <= name_word[11];
            p_mask_reg   <= n_mask_reg;
        end
    end

    // ------------------------------------------------------------------
    // Palette
    // ------------------------------------------------------------------
    tbpr_pkg::pal_wr_t                pal_wr;
    logic [tbpr_pkg::PAL_AW-1:0]      pal_raddr;
    logic [tbpr_pkg::COLOUR_W-1:0]    pal_rdata;
    logic [3:0]                       cidx;

    always_comb
    begin
        pal_wr.we    = accept && (kind == tbpr_pkg::KIND_PAL_WRITE);
        pal_wr.waddr = address[tbpr_pkg::PAL_AW-1:0];
        pal_wr.wdata = write_data[tbpr_pkg::COLOUR_W-1:0];
        // plane 0 gives the lowest colour bit
        for (int b = 0; b < tbpr_pkg::BANKS; b++)
        begin
            cidx[b] = bank_rdata[b][p_bitpos_reg];
        end
        pal_raddr = {p_palsel_reg, cidx};
    end

    tbpr_palette u_palette
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (pal_wr),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    // ------------------------------------------------------------------
    // Stage advance and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        // N always advances: accept leaves P empty for it
        n_valid_next   = accept_render;
        p_valid_next   = n_valid_reg || (p_valid_reg && !out_free);
        out_valid_next = out_valid_reg;
        colour_next    = colour_reg;
        if (p_valid_reg && out_free)
        begin
            out_valid_next = 1'b1;
            colour_next    = p_mask_reg ? '0 : pal_rdata;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_valid_reg   <= n_valid_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg <= colour_next;
    end

    assign out_valid = out_valid_reg;
    assign colour    = colour_reg;

endmodule

@@ rtl/tbpr_checker.sv @@
module tbpr_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic [1:0]                             kind,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic [tbpr_pkg::COLOUR_W-1:0]          colour
);

    // A held result beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // A held result beat keeps its colour
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(colour))
        else $error("colour changed while stalled");

    // A render holds the memory read port for its pattern read, stalling the input
    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == tbpr_pkg::KIND_RENDER) |=> in_stall)
        else $error("input taken during pattern read");

    // A fresh result always comes from an accepted render, through the N and P stages
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            $past(in_valid && !in_stall && (kind == tbpr_pkg::KIND_RENDER), 3))
        else $error("result without a matching render");

    // Writes never raise a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind != tbpr_pkg::KIND_RENDER) && !out_valid
        |=> ##1 !$rose(out_valid))
        else $error("result raised by a write");

endmodule

bind tile_background_pixel_renderer tbpr_checker u_tbpr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .colour    (colour)
);
